// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the timer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is disabled while reset is high.
`define RDT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("timer assertion failed");

// Concurrent assertion that is checked during reset as well.
`define RDT_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("timer assertion failed");

`endif

// ===== design/rdt_pkg.sv =====
// Types, codes and constants of the reload down timer.
package rdt_pkg;

   localparam int VALUE_W           = 24;
   localparam int COUNTER_WIDTH_DEF = 24;
   localparam int PRESCALE_DEF      = 8;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 24;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_READ  = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      MODE_ONE_SHOT = 2'd0,
      MODE_PERIODIC = 2'd1
   } mode_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_RELOAD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLK_SRC  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALLBACK = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] start_mode;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] count_value;
      logic               count_flag;
      logic               handler_event;
      logic               callback_event;
      logic               running;
      logic               start_error;
   } rsp_type;

   typedef struct packed {
      logic zero_flag;
      logic enabled;
      logic periodic;
      logic handler_active;
   } flags_type;

   typedef struct packed {
      logic clock_source;
      logic callback_set;
   } cfg_type;

endpackage

// ===== design/rdt_step.sv =====
// Next-state and result logic for one timer request.
module rdt_step #(
   parameter int COUNTER_WIDTH   = rdt_pkg::COUNTER_WIDTH_DEF,
   parameter int PRESCALE_DIVIDE = rdt_pkg::PRESCALE_DEF,
   parameter int PRE_W           = $clog2(PRESCALE_DIVIDE)
) (
   input  rdt_pkg::req_type             req,
   input  logic [COUNTER_WIDTH-1:0]     counter,
   input  logic [PRE_W-1:0]             prescale,
   input  rdt_pkg::flags_type           flags,
   input  rdt_pkg::cfg_type             cfg,
   input  logic [rdt_pkg::VALUE_W-1:0]  reload_value,
   output logic [COUNTER_WIDTH-1:0]     counter_next,
   output logic [PRE_W-1:0]             prescale_next,
   output rdt_pkg::flags_type           flags_next,
   output rdt_pkg::rsp_type             rsp
);
   import rdt_pkg::*;

   localparam int EXT_W = (COUNTER_WIDTH > VALUE_W) ? COUNTER_WIDTH : VALUE_W;
   localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(PRESCALE_DIVIDE - 1);

   logic [EXT_W-1:0]         reload_wide;
   logic [EXT_W-1:0]         count_wide;
   logic [COUNTER_WIDTH-1:0] reload_cnt;
   logic                     pre_wrap;
   logic                     step;
   logic                     hev;
   logic                     cev;
   logic                     err;
   logic                     flag_out;

   assign reload_wide = EXT_W'(reload_value);
   assign reload_cnt  = reload_wide[COUNTER_WIDTH-1:0];
   assign pre_wrap    = (prescale >= PRE_LAST);

   always_comb begin
      counter_next  = counter;
      prescale_next = prescale;
      flags_next    = flags;
      step          = 1'b0;
      hev           = 1'b0;
      cev           = 1'b0;
      err           = 1'b0;
      case (act_type'(req.action))
         ACT_TICK: begin
            if (flags.enabled) begin
               if (cfg.clock_source) begin
                  step = 1'b1;
               end else if (pre_wrap) begin
                  prescale_next = '0;
                  step          = 1'b1;
               end else begin
                  prescale_next = prescale + 1'b1;
               end
            end
         end
         ACT_START: begin
            if (req.start_mode != MODE_ONE_SHOT && req.start_mode != MODE_PERIODIC) begin
               err = 1'b1;
            end else begin
               counter_next              = '0;
               prescale_next             = '0;
               flags_next.zero_flag      = 1'b0;
               flags_next.periodic       = (req.start_mode == MODE_PERIODIC);
               flags_next.handler_active = 1'b1;
               flags_next.enabled        = 1'b1;
            end
         end
         ACT_STOP: begin
            flags_next.enabled = 1'b0;
         end
         default: begin
         end
      endcase

      if (step) begin
         if (counter == '0) begin
            counter_next = reload_cnt;
         end else if (counter == COUNTER_WIDTH'(1)) begin
            counter_next         = '0;
            flags_next.zero_flag = 1'b1;
            hev                  = 1'b1;
            cev                  = cfg.callback_set & flags.handler_active;
            if (!flags.periodic) begin
               flags_next.enabled        = 1'b0;
               flags_next.handler_active = 1'b0;
            end
         end else begin
            counter_next = counter - 1'b1;
         end
      end

      flag_out = flags_next.zero_flag;
      if (act_type'(req.action) == ACT_READ) begin
         flags_next.zero_flag = 1'b0;
      end
   end

   assign count_wide = EXT_W'(counter_next);

   always_comb begin
      rsp.count_value    = count_wide[VALUE_W-1:0];
      rsp.count_flag     = flag_out;
      rsp.handler_event  = hev;
      rsp.callback_event = cev;
      rsp.running        = flags_next.enabled;
      rsp.start_error    = err;
   end

endmodule

// ===== design/rdt_out_stage.sv =====
// Result register between the timer logic and the response channel.
module rdt_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  rdt_pkg::rsp_type rsp_next,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output rdt_pkg::rsp_type rsp_payload,
   output logic             space
);
   import rdt_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

// ===== design/reload_down_timer_one_shot_top.sv =====
// Top level of the reload down timer, one-shot or periodic.
//
// Requests arrive on req_valid/req_ready with an action (tick, start, stop,
// read status) and a start mode. Every request yields exactly one response
// on rsp_valid/rsp_ready carrying the counter value, the count flag, the
// handler and callback events, the running bit and a start error.
// The result register holds the response on the cycle after the request
// is taken. Throughput is one request per cycle while rsp_ready holds,
// set by that single result register; a request is taken while a response
// waits, provided the receiver takes it in the same cycle.
// When the receiver stalls, the response holds and req_ready drops until
// it is taken. Configuration writes on csr_we/csr_index/csr_wdata set the
// reload value (index 0), the clock source (index 1) and the callback
// enable (index 2); other indexes are ignored.
// Synchronous reset clears the counter, prescaler and flags but sets
// handler_active, stops the timer, selects the full-rate clock source
// and empties the result register.
module reload_down_timer_one_shot_top #(
   parameter int COUNTER_WIDTH   = rdt_pkg::COUNTER_WIDTH_DEF,
   parameter int PRESCALE_DIVIDE = rdt_pkg::PRESCALE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rdt_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rdt_pkg::rsp_type                rsp_payload,
   input  logic                            csr_we,
   input  logic [rdt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rdt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rdt_pkg::*;

   localparam int PRE_W = $clog2(PRESCALE_DIVIDE);

   logic [COUNTER_WIDTH-1:0] counter_ff;
   logic [COUNTER_WIDTH-1:0] counter_in;
   logic [PRE_W-1:0]         prescale_ff;
   logic [PRE_W-1:0]         prescale_in;
   flags_type                flags_ff;
   flags_type                flags_in;
   cfg_type                  cfg_ff;
   logic [VALUE_W-1:0]       reload_ff;
   rsp_type                  rsp_in;
   logic                     space;
   logic                     take;

   assign req_ready = space;
   assign take      = req_valid && space;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff           <= '0;
         cfg_ff.clock_source <= 1'b1;
         cfg_ff.callback_set <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RELOAD:   reload_ff           <= csr_wdata[VALUE_W-1:0];
            CSR_CLK_SRC:  cfg_ff.clock_source <= csr_wdata[0];
            CSR_CALLBACK: cfg_ff.callback_set <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff              <= '0;
         prescale_ff             <= '0;
         flags_ff.zero_flag      <= 1'b0;
         flags_ff.enabled        <= 1'b0;
         flags_ff.periodic       <= 1'b0;
         flags_ff.handler_active <= 1'b1;
      end else if (take) begin
         counter_ff  <= counter_in;
         prescale_ff <= prescale_in;
         flags_ff    <= flags_in;
      end
   end

   rdt_step #(
      .COUNTER_WIDTH   (COUNTER_WIDTH),
      .PRESCALE_DIVIDE (PRESCALE_DIVIDE),
      .PRE_W           (PRE_W)
   ) u_step (
      .req           (req_payload),
      .counter       (counter_ff),
      .prescale      (prescale_ff),
      .flags         (flags_ff),
      .cfg           (cfg_ff),
      .reload_value  (reload_ff),
      .counter_next  (counter_in),
      .prescale_next (prescale_in),
      .flags_next    (flags_in),
      .rsp           (rsp_in)
   );

   rdt_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (take),
      .rsp_next    (rsp_in),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .space       (space)
   );

endmodule

// ===== design/rdt_checker.sv =====
// Port-level checks of the reload down timer and their bind.
`include "assert_macros.svh"

module rdt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rdt_pkg::rsp_type rsp_payload
);
   import rdt_pkg::*;

   `RDT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
   `RDT_ASSERT(a_cb_needs_handler, clock, reset, rsp_valid && rsp_payload.callback_event |-> rsp_payload.handler_event)
   `RDT_ASSERT(a_expiry_at_zero, clock, reset, rsp_valid && rsp_payload.handler_event |-> rsp_payload.count_flag && rsp_payload.count_value == '0)
   `RDT_ASSERT(a_error_quiet, clock, reset, rsp_valid && rsp_payload.start_error |-> !rsp_payload.handler_event && !rsp_payload.callback_event)
   `RDT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind reload_down_timer_one_shot_top rdt_checker u_rdt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== sim/tb_reload_down_timer_one_shot_top.sv =====
// Testbench for the reload down timer: directed and random requests, each response checked.
`timescale 1ns / 1ps

module tb_reload_down_timer_one_shot_top;
   import rdt_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED      = 2'd3;
   localparam logic [1:0]             MODE_RESERVED_2 = 2'd2;
   localparam logic [1:0]             MODE_RESERVED_3 = 2'd3;
   localparam logic [VALUE_W-1:0]     RELOAD_MAX      = '1;
   localparam int QUIET_LIMIT      = 5000;
   localparam int SEGMENTS         = 8;
   localparam int SEGMENT_REQUESTS = 40;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   logic [VALUE_W-1:0] reload_value   = '0;
   logic               clock_source   = 1'b1;
   logic               callback_set   = 1'b0;
   logic [VALUE_W-1:0] count          = '0;
   logic               zero_flag      = 1'b0;
   logic               timer_enabled  = 1'b0;
   logic               periodic       = 1'b0;
   logic               handler_active = 1'b1;
   logic [2:0]         prescale_count = '0;

   rsp_type pending_responses[$];
   int      failure_count  = 0;
   int      quiet_cycles   = 0;
   int      send_idle_pct  = 23;
   int      recv_stall_pct = 81;

   reload_down_timer_one_shot_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void step_counter(output logic hev, output logic cev);
      hev = 1'b0;
      cev = 1'b0;
      if (count == '0) begin
         count = reload_value;
      end else if (count == VALUE_W'(1)) begin
         count     = '0;
         zero_flag = 1'b1;
         hev       = 1'b1;
         cev       = callback_set & handler_active;
         if (!periodic) begin
            timer_enabled  = 1'b0;
            handler_active = 1'b0;
         end
      end else begin
         count = count - 1'b1;
      end
   endfunction

   function automatic rsp_type timer_response(input req_type r);
      rsp_type rsp;
      logic    hev;
      logic    cev;
      rsp = '0;
      hev = 1'b0;
      cev = 1'b0;
      case (act_type'(r.action))
         ACT_TICK: begin
            if (timer_enabled) begin
               if (clock_source) begin
                  step_counter(hev, cev);
               end else if (prescale_count >= 3'(PRESCALE_DEF - 1)) begin
                  prescale_count = '0;
                  step_counter(hev, cev);
               end else begin
                  prescale_count = prescale_count + 1'b1;
               end
            end
         end
         ACT_START: begin
            if (r.start_mode > MODE_PERIODIC) begin
               rsp.start_error = 1'b1;
            end else begin
               count          = '0;
               zero_flag      = 1'b0;
               prescale_count = '0;
               periodic       = (r.start_mode == MODE_PERIODIC);
               handler_active = 1'b1;
               timer_enabled  = 1'b1;
            end
         end
         ACT_STOP: timer_enabled = 1'b0;
         default: ;
      endcase
      rsp.count_flag = zero_flag;
      if (act_type'(r.action) == ACT_READ) begin
         zero_flag = 1'b0;
      end
      rsp.count_value    = count;
      rsp.handler_event  = hev;
      rsp.callback_event = cev;
      rsp.running        = timer_enabled;
      return rsp;
   endfunction

   task automatic record_failure(input string msg);
      failure_count++;
      if (failure_count <= 10) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         record_failure($sformatf("%s mismatch: expected %0h, actual %0h", name, want, got));
      end
   endtask

   always @(posedge clock) begin : response_monitor
      rsp_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_RELOAD:   reload_value = csr_wdata[VALUE_W-1:0];
               CSR_CLK_SRC:  clock_source = csr_wdata[0];
               CSR_CALLBACK: callback_set = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_responses.size() == 0) begin
               record_failure($sformatf("unexpected response %h", rsp_payload));
            end else begin
               want = pending_responses.pop_front();
               check_field("count_value", 32'(want.count_value),
                           32'(rsp_payload.count_value));
               check_field("count_flag", 32'(want.count_flag),
                           32'(rsp_payload.count_flag));
               check_field("handler_event", 32'(want.handler_event),
                           32'(rsp_payload.handler_event));
               check_field("callback_event", 32'(want.callback_event),
                           32'(rsp_payload.callback_event));
               check_field("running", 32'(want.running),
                           32'(rsp_payload.running));
               check_field("start_error", 32'(want.start_error),
                           32'(rsp_payload.start_error));
            end
         end
         if (req_valid && req_ready) begin
            pending_responses.push_back(timer_response(req_payload));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_request(input act_type act, input logic [1:0] mode);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid              <= 1'b1;
      req_payload.action     <= act;
      req_payload.start_mode <= mode;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic test_stopped_timer();
      send_request(ACT_TICK, MODE_RESERVED_3);
      send_request(ACT_READ, MODE_RESERVED_3);
      send_request(ACT_STOP, MODE_RESERVED_3);
   endtask

   task automatic test_invalid_start();
      send_request(ACT_START, MODE_RESERVED_2);
      send_request(ACT_START, MODE_RESERVED_3);
   endtask

   task automatic test_one_shot_expiry();
      wait_drained();
      write_csr(CSR_RELOAD, CSR_DATA_W'(2));
      write_csr(CSR_CALLBACK, CSR_DATA_W'(1));
      send_request(ACT_START, MODE_ONE_SHOT);
      repeat (4) send_request(ACT_TICK, MODE_ONE_SHOT);
      repeat (2) send_request(ACT_READ, MODE_ONE_SHOT);
   endtask

   task automatic test_full_reload();
      wait_drained();
      write_csr(CSR_RELOAD, RELOAD_MAX);
      send_request(ACT_START, MODE_PERIODIC);
      repeat (2) send_request(ACT_TICK, MODE_PERIODIC);
      send_request(ACT_STOP, MODE_PERIODIC);
      send_request(ACT_TICK, MODE_PERIODIC);
   endtask

   task automatic test_periodic_repeat();
      wait_drained();
      write_csr(CSR_RELOAD, CSR_DATA_W'(1));
      send_request(ACT_START, MODE_PERIODIC);
      repeat (4) send_request(ACT_TICK, MODE_PERIODIC);
      send_request(ACT_READ, MODE_PERIODIC);
   endtask

   task automatic test_zero_reload();
      wait_drained();
      write_csr(CSR_RELOAD, '0);
      send_request(ACT_START, MODE_ONE_SHOT);
      repeat (2) send_request(ACT_TICK, MODE_ONE_SHOT);
   endtask

   task automatic test_random_segment(input int seg);
      logic [CSR_DATA_W-1:0] data;
      int                    pick;
      wait_drained();
      case ($urandom_range(9))
         0:       data = '0;
         1:       data = RELOAD_MAX;
         2:       data = CSR_DATA_W'($urandom);
         default: data = CSR_DATA_W'($urandom_range(4, 1));
      endcase
      write_csr(CSR_RELOAD, data);
      data    = CSR_DATA_W'($urandom);
      data[0] = seg[0];
      write_csr(CSR_CLK_SRC, data);
      data    = CSR_DATA_W'($urandom);
      data[0] = seg[1];
      write_csr(CSR_CALLBACK, data);
      if ($urandom_range(3) == 0) begin
         write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      end
      for (int i = 0; i < SEGMENT_REQUESTS; i++) begin
         pick = $urandom_range(99);
         if (i == 0 || (!timer_enabled && pick < 30) || (pick >= 90 && pick < 95)) begin
            send_request(ACT_START, 2'($urandom_range(1)));
         end else if (pick < 78) begin
            send_request(ACT_TICK, 2'($urandom));
         end else if (pick < 86) begin
            send_request(ACT_READ, 2'($urandom));
         end else if (pick < 90) begin
            send_request(ACT_STOP, 2'($urandom));
         end else begin
            send_request(act_type'($urandom_range(3)), 2'($urandom));
         end
      end
   endtask

   task automatic test_random(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         test_random_segment(seg);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_stopped_timer();
      test_invalid_start();
      test_one_shot_expiry();
      test_full_reload();
      test_periodic_repeat();
      test_zero_reload();
      test_random(23, 81);
      test_random(81, 23);
      test_random(0, 0);
      wait_drained();
      repeat (4) @(posedge clock);
      if (failure_count == 0 && pending_responses.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
